[design/rsd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package rsd_pkg;

  // RAID level codes.
  localparam logic [2:0] LVL_RAID0  = 3'd0;
  localparam logic [2:0] LVL_RAID01 = 3'd1;
  localparam logic [2:0] LVL_RAID10 = 3'd2;
  localparam logic [2:0] LVL_RAID4  = 3'd3;
  localparam logic [2:0] LVL_RAID5  = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_RAID_LEVEL    = 2'd0;
  localparam logic [1:0] CFG_DISK_COUNT    = 2'd1;
  localparam logic [1:0] CFG_CHUNK_SIZE    = 2'd2;
  localparam logic [1:0] CFG_TOTAL_STRIPES = 2'd3;

  // Largest chunk size accepted in RAID0.
  localparam logic [4:0] GROUP_LIMIT = 5'd16;

  typedef struct packed {
    logic [19:0] row_index;
    logic [3:0]  disk_index;
  } req_t;

  typedef struct packed {
    logic [23:0] sector;
    logic        is_parity;
    logic        valid_res;
  } rsp_t;

  typedef struct packed {
    logic [2:0]  raid_level;
    logic [4:0]  disk_count;
    logic [4:0]  chunk_size;
    logic [19:0] total_stripes;
  } cfg_t;

endpackage
`default_nettype wire

[design/rsd_div.sv]
`timescale 1ns / 1ps
`default_nettype none
module rsd_div #(
  parameter int W      = 20,
  parameter int STAGES = 5,
  parameter int BPS    = 4
) (
  input  wire logic              clk,
  input  wire logic [STAGES-1:0] en,
  input  wire logic [W-1:0]      dividend,
  input  wire logic [4:0]        divisor,
  output logic      [W-1:0]      quot,
  output logic      [4:0]        rem
);

  localparam int PW = STAGES * BPS;

  logic [PW-1:0] x_q   [STAGES];
  logic [PW-1:0] q_q   [STAGES];
  logic [4:0]    r_q   [STAGES];
  logic [PW-1:0] x_nxt [STAGES];
  logic [PW-1:0] q_nxt [STAGES];
  logic [4:0]    r_nxt [STAGES];

  // Restoring division, BPS quotient bits per stage, most significant first.
  always_comb begin
    logic [5:0]    rr;
    logic [4:0]    rt;
    logic [PW-1:0] xt;
    logic [PW-1:0] qt;
    for (int k = 0; k < STAGES; k++) begin
      if (k == 0) begin
        xt = PW'(dividend);
        qt = '0;
        rt = '0;
      end else begin
        xt = x_q[k-1];
        qt = q_q[k-1];
        rt = r_q[k-1];
      end
      for (int j = 0; j < BPS; j++) begin
        rr = {rt, xt[PW-1]};
        xt = {xt[PW-2:0], 1'b0};
        if (rr >= {1'b0, divisor}) begin
          rr = rr - {1'b0, divisor};
          qt = {qt[PW-2:0], 1'b1};
        end else begin
          qt = {qt[PW-2:0], 1'b0};
        end
        rt = rr[4:0];
      end
      x_nxt[k] = xt;
      q_nxt[k] = qt;
      r_nxt[k] = rt;
    end
  end

  // Stage registers advance under the pipeline enables.
  always_ff @(posedge clk) begin
    for (int k = 0; k < STAGES; k++) begin
      if (en[k]) begin
        x_q[k] <= x_nxt[k];
        q_q[k] <= q_nxt[k];
        r_q[k] <= r_nxt[k];
      end
    end
  end

  assign quot = q_q[STAGES-1][W-1:0];
  assign rem  = r_q[STAGES-1];

endmodule
`default_nettype wire

[design/rsd_map.sv]
`timescale 1ns / 1ps
`default_nettype none
module rsd_map #(
  parameter int SW        = 20,
  parameter int MAX_DISKS = 16
) (
  input  wire logic          clk,
  input  wire logic          en_mul,
  input  wire logic          en_out,
  input  wire rsd_pkg::cfg_t cfg,
  input  wire logic [SW-1:0] s,
  input  wire logic [3:0]    d,
  input  wire logic [SW-1:0] q_s,
  input  wire logic [SW-1:0] q_t,
  input  wire logic [4:0]    r_c,
  input  wire logic [4:0]    r_n,
  output rsd_pkg::rsp_t      rsp
);
  import rsd_pkg::*;

  localparam int            PRW  = SW + 10;
  localparam logic [6:0]    MAXD = 7'(MAX_DISKS);

  logic [9:0]     nc;
  logic [SW-1:0]  mul_a;
  logic [9:0]     mul_b;
  logic [PRW-1:0] prod_full;
  logic [PRW+23:0] prod_ext;
  logic [9:0]     addend;
  logic [4:0]     half;
  logic [4:0]     dd;
  logic [5:0]     rot;
  logic           ok;
  logic           par;
  logic           s_lt_t;

  logic [23:0]    prod_q;
  logic [9:0]     addend_q;
  logic           ok_q;
  logic           par_q;

  // Chunk pitch n*c is registered and follows the configuration in the next cycle.
  always_ff @(posedge clk) begin
    nc <= 10'(cfg.disk_count) * 10'(cfg.chunk_size);
  end

  // Level decode: multiplier operands, addend, parity and range checks.
  always_comb begin
    half   = {1'b0, cfg.disk_count[4:1]};
    dd     = {1'b0, d};
    rot    = {1'b0, dd} + {1'b0, r_n};
    s_lt_t = s < cfg.total_stripes[SW-1:0];
    ok     = (cfg.raid_level <= LVL_RAID5) && (cfg.disk_count >= 5'd2) &&
             ({2'b0, cfg.disk_count} <= MAXD) && (dd < cfg.disk_count);
    par    = 1'b0;
    mul_a  = s;
    mul_b  = 10'(cfg.disk_count - 5'd1);
    addend = 10'(dd);
    case (cfg.raid_level)
      LVL_RAID0: begin
        mul_a  = q_s;
        mul_b  = nc;
        addend = 10'(dd) * 10'(cfg.chunk_size) + 10'(r_c);
        ok     = ok && (cfg.chunk_size != 5'd0) &&
                 (cfg.chunk_size <= GROUP_LIMIT) && (q_s < q_t);
      end
      LVL_RAID01: begin
        mul_b  = 10'(half);
        addend = (dd >= half) ? 10'(dd - half) : 10'(dd);
        ok     = ok && !cfg.disk_count[0] && s_lt_t;
      end
      LVL_RAID10: begin
        mul_b  = 10'(half);
        addend = 10'(dd >> 1);
        ok     = ok && !cfg.disk_count[0] && s_lt_t;
      end
      LVL_RAID4: begin
        par = dd == cfg.disk_count - 5'd1;
        ok  = ok && s_lt_t;
      end
      default: begin
        par    = dd == cfg.disk_count - 5'd1 - r_n;
        addend = (rot >= {1'b0, cfg.disk_count}) ? 10'(rot - {1'b0, cfg.disk_count})
                                                 : 10'(rot);
        ok     = ok && s_lt_t;
      end
    endcase
  end

  assign prod_full = PRW'(mul_a) * PRW'(mul_b);
  assign prod_ext  = {24'd0, prod_full};

  // Multiply stage.
  always_ff @(posedge clk) begin
    if (en_mul) begin
      prod_q   <= prod_ext[23:0];
      addend_q <= addend;
      ok_q     <= ok;
      par_q    <= par && ok;
    end
  end

  // Output stage: final add and zeroing of parity and invalid places.
  always_ff @(posedge clk) begin
    if (en_out) begin
      rsp.sector    <= (ok_q && !par_q) ? prod_q + 24'(addend_q) : 24'd0;
      rsp.is_parity <= par_q;
      rsp.valid_res <= ok_q;
    end
  end

endmodule
`default_nettype wire

[design/raid_sector_to_disk_map.sv]
`timescale 1ns / 1ps
`default_nettype none
// Maps a (stripe, disk) place of a RAID0/01/10/4/5 array to the logical
// sector stored there, or flags it as parity or invalid. One word is taken
// every cycle unless req_stall is raised; each result passes through an input
// register, the pipelined dividers that yield stripe/chunk, total/chunk and
// stripe mod disk count four quotient bits per stage, a multiply stage and
// an output stage. Configuration is registered and must only change while
// idle.
module raid_sector_to_disk_map #(
  parameter int MAX_DISKS   = 16,
  parameter int STRIPE_BITS = 20
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire rsd_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output rsd_pkg::rsp_t      rsp,
  input  wire logic          cfg_write,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [19:0]   cfg_data
);
  import rsd_pkg::*;

  localparam int SW = (STRIPE_BITS < 20) ? STRIPE_BITS : 20;
  localparam int P  = (SW + 3) / 4;

  cfg_t          cfg;
  logic [P+2:0]  v;
  logic [P+3:0]  en;
  logic [SW-1:0] s_pipe [P+1];
  logic [3:0]    d_pipe [P+1];
  logic [SW-1:0] q_s;
  logic [SW-1:0] q_t;
  logic [SW-1:0] q_n_unused;
  logic [4:0]    r_c;
  logic [4:0]    r_n;
  logic [4:0]    r_t_unused;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.raid_level    <= LVL_RAID0;
      cfg.disk_count    <= 5'd2;
      cfg.chunk_size    <= 5'd1;
      cfg.total_stripes <= 20'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_RAID_LEVEL: cfg.raid_level    <= cfg_data[2:0];
        CFG_DISK_COUNT: cfg.disk_count    <= cfg_data[4:0];
        CFG_CHUNK_SIZE: cfg.chunk_size    <= cfg_data[4:0];
        default:        cfg.total_stripes <= cfg_data;
      endcase
    end
  end

  // A stage loads when it is empty or the stage after it moves on.
  always_comb begin
    en[P+3] = !rsp_stall;
    for (int k = P + 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign req_stall = !en[0];
  assign rsp_valid = v[P+2];

  // Valid bits travel with the words.
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k <= P + 2; k++) begin
        if (en[k]) begin
          v[k] <= (k == 0) ? req_valid : v[k-1];
        end
      end
    end
  end

  // Stripe and disk ride alongside the divider.
  always_ff @(posedge clk) begin
    for (int k = 0; k <= P; k++) begin
      if (en[k]) begin
        if (k == 0) begin
          s_pipe[k] <= req.row_index[SW-1:0];
          d_pipe[k] <= req.disk_index;
        end else begin
          s_pipe[k] <= s_pipe[k-1];
          d_pipe[k] <= d_pipe[k-1];
        end
      end
    end
  end

  // Stripe divided by chunk size.
  rsd_div #(.W(SW), .STAGES(P), .BPS(4)) u_div_sc (
    .clk      (clk),
    .en       (en[P:1]),
    .dividend (s_pipe[0]),
    .divisor  (cfg.chunk_size),
    .quot     (q_s),
    .rem      (r_c)
  );

  // Total stripes divided by chunk size, for the whole-group limit.
  rsd_div #(.W(SW), .STAGES(P), .BPS(4)) u_div_tc (
    .clk      (clk),
    .en       (en[P:1]),
    .dividend (cfg.total_stripes[SW-1:0]),
    .divisor  (cfg.chunk_size),
    .quot     (q_t),
    .rem      (r_t_unused)
  );

  // Stripe modulo disk count, for the RAID5 parity rotation.
  rsd_div #(.W(SW), .STAGES(P), .BPS(4)) u_div_sn (
    .clk      (clk),
    .en       (en[P:1]),
    .dividend (s_pipe[0]),
    .divisor  (cfg.disk_count),
    .quot     (q_n_unused),
    .rem      (r_n)
  );

  rsd_map #(.SW(SW), .MAX_DISKS(MAX_DISKS)) u_map (
    .clk    (clk),
    .en_mul (en[P+1]),
    .en_out (en[P+2]),
    .cfg    (cfg),
    .s      (s_pipe[P]),
    .d      (d_pipe[P]),
    .q_s    (q_s),
    .q_t    (q_t),
    .r_c    (r_c),
    .r_n    (r_n),
    .rsp    (rsp)
  );

`ifndef SYNTHESIS
  // An accepted word always lands in the first stage.
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> v[0])
    else $error("accepted word not captured");

  // Invalid places carry no sector and no parity.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.valid_res |-> rsp.sector == 24'd0 && !rsp.is_parity)
    else $error("invalid result not zeroed");

  // Parity places are valid and carry no sector.
  a_parity_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.is_parity |-> rsp.valid_res && rsp.sector == 24'd0)
    else $error("parity result malformed");
`endif

endmodule
`default_nettype wire

[dv/raid_map_checker.sv]
`timescale 1ns / 1ps
module raid_map_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_stall,
  input  rsd_pkg::req_t req,
  input  logic          rsp_valid,
  input  logic          rsp_stall,
  input  rsd_pkg::rsp_t rsp,
  input  logic          cfg_write,
  input  logic [1:0]    cfg_index,
  input  logic [19:0]   cfg_data,
  output int            errors,
  output int            pending
);
  import rsd_pkg::*;

  localparam int MAX_DISKS = 16;

  cfg_t cfg;
  rsp_t sector_queue[$];

  // Compute the sector held at one stripe and disk under the current setup.
  function automatic rsp_t map_place(cfg_t c, req_t r);
    rsp_t o;
    logic [63:0] s, d, n, g, tot, p, sec;
    logic ok, par;
    s = 64'(r.row_index);
    d = 64'(r.disk_index);
    n = 64'(c.disk_count);
    g = 64'(c.chunk_size);
    tot = 64'(c.total_stripes);
    sec = 64'd0;
    par = 1'b0;
    ok = !(c.raid_level > LVL_RAID5 || n < 2 || n > MAX_DISKS || d >= n);
    if (ok) begin
      case (c.raid_level)
        LVL_RAID0: begin
          if (g == 0 || g > GROUP_LIMIT || s >= (tot / g) * g) ok = 1'b0;
          else sec = (s / g) * n * g + d * g + s % g;
        end
        LVL_RAID01: begin
          if (n[0] || s >= tot) ok = 1'b0;
          else sec = s * (n / 2) + d % (n / 2);
        end
        LVL_RAID10: begin
          if (n[0] || s >= tot) ok = 1'b0;
          else sec = s * (n / 2) + d / 2;
        end
        LVL_RAID4: begin
          if (s >= tot) ok = 1'b0;
          else if (d == n - 1) par = 1'b1;
          else sec = s * (n - 1) + d;
        end
        default: begin
          if (s >= tot) ok = 1'b0;
          else begin
            p = (n - 1) - (s % n);
            if (d == p) par = 1'b1;
            else sec = s * (n - 1) + (d + (n - 1 - p)) % n;
          end
        end
      endcase
    end
    if (!ok) begin
      sec = 64'd0;
      par = 1'b0;
    end
    o.sector = sec[23:0];
    o.is_parity = par;
    o.valid_res = ok;
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Track register writes and check each word that leaves the block.
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      cfg <= '{raid_level: LVL_RAID0, disk_count: 5'd2, chunk_size: 5'd1,
               total_stripes: 20'd0};
      errors = 0;
      sector_queue.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_RAID_LEVEL: cfg.raid_level <= cfg_data[2:0];
          CFG_DISK_COUNT: cfg.disk_count <= cfg_data[4:0];
          CFG_CHUNK_SIZE: cfg.chunk_size <= cfg_data[4:0];
          default:        cfg.total_stripes <= cfg_data;
        endcase
      end
      if (req_valid && !req_stall) sector_queue.push_back(map_place(cfg, req));
      if (rsp_valid && !rsp_stall) begin
        if (sector_queue.size() == 0) begin
          $display("unexpected word at %0t", $realtime);
          errors++;
        end else begin
          want = sector_queue.pop_front();
          if (rsp.sector !== want.sector)
            report_mismatch("sector", int'(rsp.sector), int'(want.sector));
          if (rsp.is_parity !== want.is_parity)
            report_mismatch("is_parity", int'(rsp.is_parity), int'(want.is_parity));
          if (rsp.valid_res !== want.valid_res)
            report_mismatch("valid_res", int'(rsp.valid_res), int'(want.valid_res));
        end
      end
    end
    pending = sector_queue.size();
  end
endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import rsd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = CFG_RAID_LEVEL;
  logic [19:0] cfg_data = '0;
  int errors, pending, cycles = 0;
  bit calm = 1'b0;
  bit hold_off = 1'b0;

  raid_sector_to_disk_map i_dut (
    .clk, .rst, .req_valid, .req_stall, .req, .rsp_valid, .rsp_stall, .rsp,
    .cfg_write, .cfg_index, .cfg_data
  );

  raid_map_checker i_checker (
    .clk, .rst, .req_valid, .req_stall, .req, .rsp_valid, .rsp_stall, .rsp,
    .cfg_write, .cfg_index, .cfg_data, .errors, .pending
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Timeout guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver side: random stall bursts, or a long hold-off when asked.
  always @(negedge clk) begin
    int burst;
    if (hold_off) rsp_stall <= 1'b1;
    else if (!calm && $urandom_range(0, 5) == 0) begin
      burst = $urandom_range(1, 4);
      rsp_stall <= 1'b1;
      repeat (burst - 1) @(negedge clk);
    end else rsp_stall <= 1'b0;
  end

  task automatic write_reg(logic [1:0] idx, logic [19:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic setup(logic [2:0] lvl, logic [4:0] disks, logic [4:0] group,
                       logic [19:0] stripes);
    write_reg(CFG_RAID_LEVEL, 20'(lvl));
    write_reg(CFG_DISK_COUNT, 20'(disks));
    write_reg(CFG_CHUNK_SIZE, 20'(group));
    write_reg(CFG_TOTAL_STRIPES, stripes);
  endtask

  // Offer one word and hold it until accepted, with optional idle bursts first.
  task automatic send_word(logic [19:0] s, logic [3:0] d);
    if (!calm && $urandom_range(0, 5) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= '{row_index: s, disk_index: d};
    @(posedge clk);
    while (req_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  // Stripe index mostly in range, sometimes anywhere.
  function automatic logic [19:0] pick_stripe(logic [19:0] stripes);
    if (stripes != 0 && $urandom_range(0, 3) != 0)
      return 20'($urandom_range(0, stripes - 1));
    return 20'($urandom);
  endfunction

  initial begin
    logic [2:0] lvl;
    logic [4:0] disks, group;
    logic [19:0] stripes;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: defaults, then extremes and every level.
    send_word(20'd0, 4'd0);
    send_word(20'hFFFFF, 4'hF);
    drain();
    setup(LVL_RAID0, 5'd16, 5'd16, 20'hFFFFF);
    send_word(20'd0, 4'd0);
    send_word(20'hFFFEF, 4'hF);
    send_word(20'hFFFF0, 4'd3);
    drain();
    setup(LVL_RAID0, 5'd4, 5'd0, 20'd100);
    send_word(20'd5, 4'd1);
    drain();
    setup(LVL_RAID01, 5'd5, 5'd1, 20'd100);
    send_word(20'd5, 4'd1);
    drain();
    setup(LVL_RAID10, 5'd16, 5'd1, 20'hFFFFF);
    send_word(20'hFFFFE, 4'hF);
    send_word(20'hFFFFF, 4'd0);
    drain();
    setup(LVL_RAID4, 5'd16, 5'd1, 20'hFFFFF);
    send_word(20'hFFFFE, 4'hF);
    send_word(20'hFFFFE, 4'hE);
    drain();
    setup(LVL_RAID5, 5'd5, 5'd1, 20'd50);
    for (int s = 0; s < 5; s++) send_word(20'(s), 4'(4 - s));
    send_word(20'd2, 4'd7);
    drain();
    setup(3'd7, 5'd17, 5'd31, 20'd10);
    send_word(20'd1, 4'd1);
    drain();

    // Random phases under varied settings.
    for (int ph = 0; ph < 26; ph++) begin
      lvl = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                        : 3'($urandom_range(0, 4));
      disks = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                          : 5'($urandom_range(2, 16));
      group = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                          : 5'($urandom_range(1, 16));
      stripes = ($urandom_range(0, 3) == 0) ? 20'($urandom)
                                            : 20'($urandom_range(1, 4000));
      if (ph >= 22) calm = 1'b1;
      setup(lvl, disks, group, stripes);
      if (ph == 3) begin
        // Hold the receiver off long enough for the block to fill and stall.
        fork
          begin
            hold_off = 1'b1;
            repeat (60) @(negedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      for (int k = 0; k < 50; k++)
        send_word(pick_stripe(stripes),
                  $urandom_range(0, 3) == 0 ? 4'($urandom)
                                            : 4'($urandom_range(0, disks - 1)));
      drain();
    end

    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
